FILE: rtl/rci_pkg.sv
// Shared types, constants and helper functions of the radix integer-to-ASCII converter.
`default_nettype none

package rci_pkg;

   // Width of the value that is converted; only its low VALUE_BITS bits take part.
   localparam int VALUE_BITS  = 64;
   localparam int NUMBER_W    = 64;

   // Serial divider: one nibble of the quotient per cycle.
   localparam int CHUNK_BITS  = 4;
   localparam int DIV_STEPS   = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int QUOT_W      = DIV_STEPS * CHUNK_BITS;
   localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Digit buffer holds one entry for each possible digit.
   localparam int STORE_DEPTH = VALUE_BITS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(VALUE_BITS + 1);

   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 6;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
   localparam logic [DIGIT_W-1:0] RADIX_RESET = 4'd10;
   localparam logic [DIGIT_W-1:0] BASE_MIN    = 4'd2;
   localparam logic [DIGIT_W-1:0] BASE_MAX    = 4'd10;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [0:0] {
      CSR_RADIX = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // One digit leaving the divider.
   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } digit_type;

   // Bases outside two to ten are clamped to the nearest end of that range.
   function automatic logic [DIGIT_W-1:0] eff_base(input logic [DIGIT_W-1:0] radix);
      logic [DIGIT_W-1:0] result;
      if (radix < BASE_MIN) begin
         result = BASE_MIN;
      end else if (radix > BASE_MAX) begin
         result = BASE_MAX;
      end else begin
         result = radix;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/radix_integer_to_ascii_top.sv
// Top level of the radix integer-to-ASCII converter: control, digit buffer and ports.
// An item with n digits runs each digit through a full pass of the nibble-serial divider,
// then the digit buffer is read back one character at a time, most significant digit first.
// The first character follows once the last digit of the item has been divided out.
// A new item is taken while the final character of the previous one still waits.
// Reset is synchronous and active high; it sets the radix to ten and idles the block.
`default_nettype none

module radix_integer_to_ascii_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: number[63:0]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rci_pkg::NUMBER_W-1:0]      req_tdata,
   // rsp_tdata: digit_char[5:0], zeros[7:6]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [rci_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rci_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [rci_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [rci_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   import rci_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [DIGIT_W-1:0] radix_ff;
   logic [DIGIT_W-1:0] radix_in;
   logic [CNT_W-1:0]   wr_cnt_ff;
   logic [CNT_W-1:0]   wr_cnt_in;
   logic [CNT_W-1:0]   rd_left_ff;
   logic [CNT_W-1:0]   rd_left_in;
   logic               rd_pend_ff;
   logic               rd_pend_in;
   logic               pend_last_ff;
   logic               pend_last_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff;
   logic [CHAR_W-1:0]  out_char_in;
   logic               out_last_ff;
   logic               out_last_in;

   logic               req_xfer;
   logic               rd_issue;
   logic               csr_write;
   csr_index_type      csr_index;
   logic [DIGIT_W-1:0] ram_q;
   digit_type          digit;

   assign req_xfer  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      radix_in   = radix_ff;
      csr_prdata = '0;
      unique case (csr_index)
         CSR_RADIX: begin
            csr_prdata = CSR_DATA_W'(radix_ff);
            if (csr_write) begin
               radix_in = csr_pwdata[DIGIT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   rci_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .start_value (QUOT_W'(req_tdata[VALUE_BITS-1:0])),
      .start_base  (eff_base(radix_ff)),
      .digit       (digit)
   );

   rci_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (digit.valid),
      .wr_addr (wr_cnt_ff[ADDR_W-1:0]),
      .wr_data (digit.digit),
      .rd_en   (rd_issue),
      .rd_addr (ADDR_W'(rd_left_ff - 1'b1)),
      .rd_data (ram_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (digit.valid && digit.last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rd_issue && (rd_left_ff == CNT_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      rd_issue   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_DIVIDE: begin
            req_tready = 1'b0;
         end
         ST_EMIT: begin
            rd_issue = (rd_left_ff != '0) && !rd_pend_ff && (!out_valid_ff || rsp_tready);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_cnt_in    = wr_cnt_ff;
      rd_left_in   = rd_left_ff;
      rd_pend_in   = rd_issue;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (req_xfer) begin
         wr_cnt_in = '0;
      end else if (digit.valid) begin
         wr_cnt_in = wr_cnt_ff + 1'b1;
      end

      if (digit.valid && digit.last) begin
         rd_left_in = wr_cnt_ff + 1'b1;
      end else if (rd_issue) begin
         rd_left_in   = rd_left_ff - 1'b1;
         pend_last_in = (rd_left_ff == CNT_W'(1));
      end

      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
         out_char_in  = ASCII_ZERO + CHAR_W'(ram_q);
         out_last_in  = pend_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         wr_cnt_ff    <= '0;
         rd_left_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         wr_cnt_ff    <= wr_cnt_in;
         rd_left_ff   <= rd_left_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      pend_last_ff <= pend_last_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_char_ff);
   assign rsp_tlast  = out_last_ff;

   a_pend_into_empty: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !out_valid_ff)
      else $error("buffer read returned while the output register was full");

   a_digit_in_divide: assert property (@(posedge clock) disable iff (reset)
      digit.valid |-> (state_ff == ST_DIVIDE))
      else $error("divider produced a digit outside the divide phase");

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (rd_left_ff != '0))
      else $error("emit phase entered with no digits left");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rd_left_ff <= CNT_W'(VALUE_BITS)) && (wr_cnt_ff <= CNT_W'(VALUE_BITS)))
      else $error("digit counter exceeds the buffer depth");

endmodule

`default_nettype wire

FILE: rtl/rci_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module rci_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rci_divider.sv
// Serial divider that peels off base digits, one quotient nibble per cycle.
`default_nettype none

module rci_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rci_pkg::QUOT_W-1:0]    start_value,
   input  wire logic [rci_pkg::DIGIT_W-1:0]   start_base,
   output rci_pkg::digit_type                 digit
);

   import rci_pkg::*;

   logic                busy_ff;
   logic                busy_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [QUOT_W-1:0]   quot_ff;
   logic [QUOT_W-1:0]   quot_in;
   logic [QUOT_W-1:0]   quot_next;
   logic [DIGIT_W-1:0]  rem_ff;
   logic [DIGIT_W-1:0]  rem_in;
   logic [DIGIT_W-1:0]  base_ff;
   logic [DIGIT_W-1:0]  base_in;
   logic [DIGIT_W:0]    rem_acc;
   logic [DIGIT_W:0]    trial;
   logic [CHUNK_BITS-1:0] qbits;
   logic                last_step;
   logic                quot_zero;

   // Restoring division over the top nibble of the shifting quotient.
   always_comb begin
      rem_acc = {1'b0, rem_ff};
      trial   = '0;
      qbits   = '0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         trial = {rem_acc[DIGIT_W-1:0], quot_ff[QUOT_W-1-i]};
         if (trial >= {1'b0, base_ff}) begin
            qbits[CHUNK_BITS-1-i] = 1'b1;
            rem_acc = trial - {1'b0, base_ff};
         end else begin
            rem_acc = trial;
         end
      end
      quot_next = {quot_ff[QUOT_W-CHUNK_BITS-1:0], qbits};
   end

   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign quot_zero = (quot_next == '0);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      base_in = base_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = start_value;
         rem_in  = '0;
         base_in = start_base;
      end else if (busy_ff) begin
         quot_in = quot_next;
         if (last_step) begin
            step_in = '0;
            rem_in  = '0;
            busy_in = !quot_zero;
         end else begin
            step_in = step_ff + 1'b1;
            rem_in  = rem_acc[DIGIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
   end

   assign digit.valid = busy_ff && last_step;
   assign digit.digit = rem_acc[DIGIT_W-1:0];
   assign digit.last  = quot_zero;

endmodule

`default_nettype wire

FILE: bench/radix_integer_to_ascii_top_tb.sv
// Self-checking testbench for the radix integer-to-ASCII converter top level.
`default_nettype none

module radix_integer_to_ascii_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rci_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] RADIX_ADDR = CSR_ADDR_W'(4 * int'(CSR_RADIX));
   localparam int HOLD_OFF_CYCLES = 3000;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [NUMBER_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [NUMBER_W-1:0]   number_queue[$];
   digit_char_type        expected_chars[$];
   digit_char_type        oldest_char;
   logic [DIGIT_W-1:0]    radix_setting = RADIX_RESET;
   logic                  req_taken = 1'b0;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    hold_off_requests = 0;
   int                    hold_off_served = 0;
   int                    hold_off_left = 0;
   int                    failures = 0;

   radix_integer_to_ascii_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_digits(input logic [NUMBER_W-1:0] number);
      logic [NUMBER_W-1:0] quotient;
      logic [NUMBER_W-1:0] base;
      logic [DIGIT_W-1:0]  digits[$];
      digit_char_type      entry;
      base = (radix_setting < BASE_MIN) ? NUMBER_W'(BASE_MIN) :
             (radix_setting > BASE_MAX) ? NUMBER_W'(BASE_MAX) : NUMBER_W'(radix_setting);
      quotient = number & ({NUMBER_W{1'b1}} >> (NUMBER_W - VALUE_BITS));
      do begin
         digits.push_front(DIGIT_W'(quotient % base));
         quotient = quotient / base;
      end while (quotient != 0);
      foreach (digits[i]) begin
         entry.digit_char = ASCII_ZERO + CHAR_W'(digits[i]);
         entry.last_digit = (i == digits.size() - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   function automatic logic [NUMBER_W-1:0] random_number();
      logic [NUMBER_W-1:0] value;
      int                  width;
      value = {$urandom(), $urandom()};
      if ($urandom_range(19) == 0) begin
         return '0;
      end
      width = ($urandom_range(7) == 0) ? NUMBER_W : $urandom_range(20, 1);
      return value >> (NUMBER_W - width);
   endfunction

   function automatic logic [DIGIT_W-1:0] random_radix();
      if ($urandom_range(5) == 0) begin
         return DIGIT_W'($urandom_range(15));
      end
      return DIGIT_W'($urandom_range(10, 2));
   endfunction

   // Feeds numbers from the queue; a new one is offered only once the last was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (number_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= number_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predict_digits(req_tdata);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == RADIX_ADDR) begin
            radix_setting = csr_pwdata[DIGIT_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected transfer: digit_char %0d, last_digit %0b",
                      rsp_tdata[CHAR_W-1:0], rsp_tlast);
               failures++;
            end else begin
               oldest_char = expected_chars.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== oldest_char.digit_char) begin
                  $error("digit_char: expected %0d, actual %0d",
                         oldest_char.digit_char, rsp_tdata[CHAR_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[RSP_DATA_W-1:CHAR_W] !== '0) begin
                  $error("rsp_tdata padding: expected 0, actual %0d",
                         rsp_tdata[RSP_DATA_W-1:CHAR_W]);
                  failures++;
               end
               if (rsp_tlast !== oldest_char.last_digit) begin
                  $error("last_digit: expected %0b, actual %0b",
                         oldest_char.last_digit, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

   task automatic wait_until_drained();
      do begin
         @(negedge clock);
         #1;
      end while (number_queue.size() != 0 || req_tvalid || expected_chars.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_radix(input logic [DIGIT_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RADIX_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_group(input logic [DIGIT_W-1:0] value, input int count);
      wait_until_drained();
      write_radix(value);
      repeat (count) number_queue.push_back(random_number());
   endtask

   initial begin
      int idle_modes[4][2];
      idle_modes = '{'{0, 0}, '{55, 0}, '{0, 55}, '{18, 18}};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset radix of ten, then the extremes of the number field.
      number_queue = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd12345678901234567890,
                       64'h8000_0000_0000_0000, {NUMBER_W{1'b1}}};
      wait_until_drained();
      write_radix(BASE_MIN);
      number_queue = '{64'd0, 64'd1, {NUMBER_W{1'b1}}, 64'h8000_0000_0000_0000,
                       64'h5555_5555_5555_5555};
      wait_until_drained();
      write_radix(4'd0);
      number_queue = '{64'd5, 64'd0};
      wait_until_drained();
      write_radix(4'd1);
      number_queue = '{64'd6};
      wait_until_drained();
      write_radix(4'd11);
      number_queue = '{64'd1000, 64'hAAAA_AAAA_AAAA_AAAA};
      wait_until_drained();
      write_radix(4'd15);
      number_queue = '{64'd99};
      wait_until_drained();
      write_radix(4'd7);
      number_queue = '{64'd48, 64'd343};

      for (int mode = 0; mode < 4; mode++) begin
         wait_until_drained();
         send_idle_pct = idle_modes[mode][0];
         stall_pct     = idle_modes[mode][1];
         run_group(BASE_MIN, 5);
         if (mode == 0) begin
            @(posedge clock);
            hold_off_requests++;
         end
         run_group(BASE_MAX, 5);
         run_group(random_radix(), 5);
         run_group(random_radix(), 5);
         run_group(random_radix(), 5);
      end

      wait_until_drained();
      repeat (40) @(negedge clock);
      if (failures == 0 && expected_chars.size() == 0) begin
         $display("radix_integer_to_ascii_top_tb: PASS");
      end else begin
         $display("radix_integer_to_ascii_top_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("radix_integer_to_ascii_top_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
